// File: src/descriptor_index_allocator_core_macros.svh
// Assertion macros for the descriptor index allocator
`ifndef DESCRIPTOR_INDEX_ALLOCATOR_CORE_MACROS_SVH
`define DESCRIPTOR_INDEX_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define DIA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DIA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/dia_pkg.sv
// Shared types and constants of the descriptor index allocator
package dia_pkg;

  localparam int unsigned MAX_SLOTS = 1024;
  localparam int unsigned SLOT_W    = 10;
  localparam int unsigned DEPTH_W   = $clog2(MAX_SLOTS) + 1;
  localparam int unsigned ADDR_W    = $clog2(MAX_SLOTS);
  localparam int unsigned HEAP_W    = 11;
  localparam int unsigned STRIDE_W  = 13;
  localparam int unsigned VA_W      = 64;
  localparam int unsigned PROD_W    = SLOT_W + STRIDE_W;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_FREE = 2'd2,
    ST_NO_GPU   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAP_SIZE      = 3'd0,
    CFG_CPU_BASE       = 3'd1,
    CFG_GPU_BASE       = 3'd2,
    CFG_SLOT_STRIDE    = 3'd3,
    CFG_SHADER_VISIBLE = 3'd4
  } cfg_idx_t;

  localparam logic [HEAP_W-1:0]   HEAP_SIZE_RST = HEAP_W'(1024);
  localparam logic [STRIDE_W-1:0] STRIDE_RST    = STRIDE_W'(32);

endpackage

// File: src/descriptor_index_allocator_core.sv
// Descriptor slot index allocator: LIFO free stack with a bump counter
//
// Input channel (in_valid/in_ready): in_kind selects allocate or free,
// in_free_slot is the index returned by a free. Each transfer yields
// exactly one result on the output channel (out_valid/out_ready): the
// slot, its CPU and GPU addresses (base + slot * stride) and a status.
// Stages from input transfer to out_valid: stack update, slot times
// stride product, 64-bit base add. Throughput is one item per cycle
// unless out_ready stalls; the free stack keeps its top two entries in
// flops and prefetches the third from the single-port-read stack RAM on
// each pop. When the receiver stalls, the three stage registers fill
// and in_ready drops; nothing is lost or repeated.
// Reset empties the stack and the bump counter and loads the register
// defaults (heap 1024 slots, stride 32, bases 0, not shader visible).
// The stack RAM is not cleared; entries above the depth are never used.
// cfg_we writes register cfg_index with cfg_wdata; write only when idle.
module descriptor_index_allocator_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [dia_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dia_pkg::VA_W-1:0]           cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_kind,
  input  logic [dia_pkg::SLOT_W-1:0]         in_free_slot,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [dia_pkg::SLOT_W-1:0]         out_slot,
  output logic [dia_pkg::VA_W-1:0]           out_cpu_address,
  output logic [dia_pkg::VA_W-1:0]           out_gpu_address,
  output logic [1:0]                         out_status
);

  `include "descriptor_index_allocator_core_macros.svh"

  // configuration
  logic [dia_pkg::HEAP_W-1:0]   heap_size_r;
  logic [dia_pkg::VA_W-1:0]     cpu_base_r;
  logic [dia_pkg::VA_W-1:0]     gpu_base_r;
  logic [dia_pkg::STRIDE_W-1:0] slot_stride_r;
  logic                         shader_visible_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_size_r      <= dia_pkg::HEAP_SIZE_RST;
      cpu_base_r       <= '0;
      gpu_base_r       <= '0;
      slot_stride_r    <= dia_pkg::STRIDE_RST;
      shader_visible_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dia_pkg::CFG_HEAP_SIZE:      heap_size_r <= cfg_wdata[dia_pkg::HEAP_W-1:0];
        dia_pkg::CFG_CPU_BASE:       cpu_base_r <= cfg_wdata;
        dia_pkg::CFG_GPU_BASE:       gpu_base_r <= cfg_wdata;
        dia_pkg::CFG_SLOT_STRIDE:    slot_stride_r <= cfg_wdata[dia_pkg::STRIDE_W-1:0];
        dia_pkg::CFG_SHADER_VISIBLE: shader_visible_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic s1_v_r, s2_v_r, s3_v_r;
  logic s1_rdy, s2_rdy, s3_rdy;
  logic in_fire;

  assign s3_rdy   = !s3_v_r || out_ready;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_ready = s1_rdy;
  assign in_fire  = in_valid && in_ready;

  // stack state
  logic [dia_pkg::DEPTH_W-1:0] depth_r, depth_nxt;
  logic [dia_pkg::DEPTH_W-1:0] fresh_r, fresh_nxt;
  logic [dia_pkg::SLOT_W-1:0]  tos_r, tos_nxt;
  logic [dia_pkg::SLOT_W-1:0]  nos_r, nos_nxt;
  logic                        nos_sel_r, nos_sel_nxt;
  logic [dia_pkg::SLOT_W-1:0]  rd_data_r;
  logic [dia_pkg::SLOT_W-1:0]  nos_cur;
  logic [dia_pkg::SLOT_W-1:0]  stack_mem [dia_pkg::MAX_SLOTS];

  logic [dia_pkg::DEPTH_W-1:0] limit;
  logic [dia_pkg::DEPTH_W-1:0] rd_sum;
  logic is_alloc, do_pop, do_fresh, do_push;
  logic mem_we, mem_re;
  logic [dia_pkg::ADDR_W-1:0] wr_addr, rd_addr;
  logic [dia_pkg::SLOT_W-1:0] s1_slot_nxt;
  dia_pkg::status_t           s1_status_nxt, ok_code;

  assign limit = (dia_pkg::DEPTH_W'(heap_size_r) < dia_pkg::DEPTH_W'(dia_pkg::MAX_SLOTS))
               ? dia_pkg::DEPTH_W'(heap_size_r) : dia_pkg::DEPTH_W'(dia_pkg::MAX_SLOTS);
  assign nos_cur  = nos_sel_r ? rd_data_r : nos_r;
  assign is_alloc = (dia_pkg::kind_t'(in_kind) == dia_pkg::KIND_ALLOC);
  assign do_pop   = is_alloc && (depth_r != '0);
  assign do_fresh = is_alloc && (depth_r == '0) && (fresh_r < limit);
  assign do_push  = !is_alloc && (dia_pkg::DEPTH_W'(in_free_slot) < fresh_r)
                 && (depth_r < dia_pkg::DEPTH_W'(dia_pkg::MAX_SLOTS));
  assign ok_code  = shader_visible_r ? dia_pkg::ST_OK : dia_pkg::ST_NO_GPU;
  assign rd_sum   = depth_r - dia_pkg::DEPTH_W'(3);
  assign rd_addr  = rd_sum[dia_pkg::ADDR_W-1:0];
  assign wr_addr  = depth_r[dia_pkg::ADDR_W-1:0];
  assign mem_we   = in_fire && do_push;
  assign mem_re   = in_fire && do_pop;

  always_comb begin
    depth_nxt   = depth_r;
    fresh_nxt   = fresh_r;
    tos_nxt     = tos_r;
    nos_nxt     = nos_r;
    nos_sel_nxt = nos_sel_r;
    if (in_fire && do_pop) begin
      depth_nxt   = depth_r - dia_pkg::DEPTH_W'(1);
      tos_nxt     = nos_cur;
      nos_sel_nxt = 1'b1;
    end else if (in_fire && do_fresh) begin
      fresh_nxt = fresh_r + dia_pkg::DEPTH_W'(1);
    end else if (in_fire && do_push) begin
      depth_nxt   = depth_r + dia_pkg::DEPTH_W'(1);
      tos_nxt     = in_free_slot;
      nos_nxt     = tos_r;
      nos_sel_nxt = 1'b0;
    end
  end

  always_comb begin
    priority if (do_pop) begin
      s1_slot_nxt   = tos_r;
      s1_status_nxt = ok_code;
    end else if (do_fresh) begin
      s1_slot_nxt   = fresh_r[dia_pkg::SLOT_W-1:0];
      s1_status_nxt = ok_code;
    end else if (is_alloc) begin
      s1_slot_nxt   = '0;
      s1_status_nxt = dia_pkg::ST_FULL;
    end else if (do_push) begin
      s1_slot_nxt   = in_free_slot;
      s1_status_nxt = ok_code;
    end else begin
      s1_slot_nxt   = in_free_slot;
      s1_status_nxt = dia_pkg::ST_BAD_FREE;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[wr_addr] <= in_free_slot;
    end
    if (mem_re) begin
      rd_data_r <= stack_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r   <= '0;
      fresh_r   <= '0;
      nos_sel_r <= 1'b0;
    end else begin
      depth_r   <= depth_nxt;
      fresh_r   <= fresh_nxt;
      nos_sel_r <= nos_sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tos_r <= tos_nxt;
    nos_r <= nos_nxt;
  end

  // stage registers
  logic [dia_pkg::SLOT_W-1:0] s1_slot_r, s2_slot_r, s3_slot_r;
  dia_pkg::status_t           s1_status_r, s2_status_r, s3_status_r;
  logic [dia_pkg::PROD_W-1:0] s2_prod_r;
  logic [dia_pkg::VA_W-1:0]   s3_cpu_r, s3_gpu_r;
  logic                       s2_ok, s2_gpu_ok;

  assign s2_ok     = (s2_status_r == dia_pkg::ST_OK) || (s2_status_r == dia_pkg::ST_NO_GPU);
  assign s2_gpu_ok = (s2_status_r == dia_pkg::ST_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_fire;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (s3_rdy) s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_slot_r   <= s1_slot_nxt;
      s1_status_r <= s1_status_nxt;
    end
    if (s1_v_r && s2_rdy) begin
      s2_slot_r   <= s1_slot_r;
      s2_status_r <= s1_status_r;
      s2_prod_r   <= dia_pkg::PROD_W'(s1_slot_r) * dia_pkg::PROD_W'(slot_stride_r);
    end
    if (s2_v_r && s3_rdy) begin
      s3_slot_r   <= s2_slot_r;
      s3_status_r <= s2_status_r;
      s3_cpu_r    <= s2_ok ? cpu_base_r + dia_pkg::VA_W'(s2_prod_r) : '0;
      s3_gpu_r    <= s2_gpu_ok ? gpu_base_r + dia_pkg::VA_W'(s2_prod_r) : '0;
    end
  end

  assign out_valid       = s3_v_r;
  assign out_slot        = s3_slot_r;
  assign out_cpu_address = s3_cpu_r;
  assign out_gpu_address = s3_gpu_r;
  assign out_status      = s3_status_r;

  // checks
  logic                          out_err, out_addr_zero, cnt_in_range;
  logic [dia_pkg::DEPTH_W-1:0]   depth_dec;
  logic [2*dia_pkg::SLOT_W-1:0]  push_top;

  assign out_err       = out_valid && (out_status == dia_pkg::ST_FULL
                                       || out_status == dia_pkg::ST_BAD_FREE);
  assign out_addr_zero = (out_cpu_address == '0) && (out_gpu_address == '0);
  assign cnt_in_range  = (depth_r <= dia_pkg::DEPTH_W'(dia_pkg::MAX_SLOTS))
                      && (fresh_r <= dia_pkg::DEPTH_W'(dia_pkg::MAX_SLOTS));
  assign depth_dec     = depth_r - dia_pkg::DEPTH_W'(1);
  assign push_top      = {in_free_slot, tos_r};

  `DIA_ASSERT_NOW(a_err_no_addr, out_err, out_addr_zero, "error result carries an address")
  `DIA_ASSERT_NOW(a_depth_bound, 1'b1, cnt_in_range, "depth or bump counter out of range")
  `DIA_ASSERT_NEXT(a_pop_depth, mem_re, depth_r == $past(depth_dec), "pop did not lower depth")
  `DIA_ASSERT_NEXT(a_push_tos, mem_we, {tos_r, nos_r} === $past(push_top), "push lost stack top")

endmodule
